// File: rtl/request_retry_timeout_table_macros.svh
// Assertion macros for the request retry timeout table.
`ifndef REQUEST_RETRY_TIMEOUT_TABLE_MACROS_SVH
`define REQUEST_RETRY_TIMEOUT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RRTT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RRTT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rrtt_pkg.sv
// Shared types and constants of the request retry timeout table.
`default_nettype none

package rrtt_pkg;

  localparam int DEST_W   = 8;
  localparam int INST_W   = 5;
  localparam int HANDLE_W = 8;
  localparam int RETRY_W  = 8;
  localparam int DELAY_W  = 16;
  localparam int TIME_W   = 24;
  localparam int CFG_W    = 16;
  localparam int TICK_MS  = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_RESP = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    EV_TRANSMIT  = 3'd0,
    EV_MATCHED   = 3'd1,
    EV_TIMEOUT   = 3'd2,
    EV_UNMATCHED = 3'd3,
    EV_FULL      = 3'd4
  } ev_kind_t;

  typedef enum logic [0:0] {
    CFG_MAX_RETRIES = 1'b0,
    CFG_RETRY_DELAY = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [DEST_W-1:0]   dest;
    logic [INST_W-1:0]   inst;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   time_left;
    logic [RETRY_W-1:0]  retries;
  } entry_t;

  typedef struct packed {
    ev_kind_t            kind;
    logic [DEST_W-1:0]   dest;
    logic [HANDLE_W-1:0] handle;
    logic [INST_W-1:0]   inst;
  } evt_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic back_vld;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/rrtt_cell.sv
// One table cell: holds an entry, loads a push, shifts toward the head.
`default_nettype none

module rrtt_cell import rrtt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_ctl_t ctl,
  input  wire logic      prev_vld,
  input  wire logic      next_vld,
  input  wire entry_t    next_ent,
  input  wire entry_t    push_ent,
  input  wire entry_t    back_ent,
  output logic           vld,
  output entry_t         ent
);

  logic   vld_r;
  logic   vld_nxt;
  entry_t ent_r;
  entry_t ent_nxt;

  always_comb begin
    vld_nxt = vld_r;
    ent_nxt = ent_r;
    if (ctl.load && !vld_r && prev_vld) begin
      vld_nxt = 1'b1;
      ent_nxt = push_ent;
    end else if (ctl.shift && vld_r) begin
      if (next_vld) begin
        ent_nxt = next_ent;
      end else begin
        // tail of the queue takes the processed head
        vld_nxt = ctl.back_vld;
        ent_nxt = back_ent;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign vld = vld_r;
  assign ent = ent_r;

endmodule

`default_nettype wire

// File: rtl/rrtt_head.sv
// Head evaluation: ages, retransmits, expires or matches the head entry.
`default_nettype none

module rrtt_head import rrtt_pkg::*; (
  input  wire entry_t             head_ent,
  input  wire op_t                op,
  input  wire logic [INST_W-1:0]  inst,
  input  wire logic               hit,
  input  wire logic [DELAY_W-1:0] delay,
  output logic                    keep,
  output entry_t                  back_ent,
  output logic                    ev_vld,
  output evt_t                    ev
);

  logic [TIME_W-1:0] time_dec;
  logic [TIME_W-1:0] lim;

  always_comb begin
    time_dec = (head_ent.time_left > TIME_W'(TICK_MS)) ?
               head_ent.time_left - TIME_W'(TICK_MS) : '0;
    lim       = TIME_W'(head_ent.retries) * TIME_W'(delay);
    keep      = 1'b1;
    back_ent  = head_ent;
    ev_vld    = 1'b0;
    ev.kind   = EV_TRANSMIT;
    ev.dest   = head_ent.dest;
    ev.handle = head_ent.handle;
    ev.inst   = head_ent.inst;
    case (op)
      OP_TICK: begin
        back_ent.time_left = time_dec;
        if (time_dec == '0) begin
          keep    = 1'b0;
          ev_vld  = 1'b1;
          ev.kind = EV_TIMEOUT;
        end else if (head_ent.retries != '0 && time_dec <= lim) begin
          ev_vld           = 1'b1;
          back_ent.retries = head_ent.retries - RETRY_W'(1);
        end
      end
      OP_RESP: begin
        if (!hit && head_ent.inst == inst) begin
          keep    = 1'b0;
          ev_vld  = 1'b1;
          ev.kind = EV_MATCHED;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/request_retry_timeout_table.sv
// Push: multiply, write and output states in turn; a push on a full table gives EV_FULL.
// Response / tick: one entry per cycle through the head unit while the output is free, over
// cnt entries (cnt = entries held, at most TABLE_DEPTH); results at most one a cycle.
// Tick on an empty table gives no result; response on an empty table gives one unmatched result.
// A held output stalls the entry rotation; one request is in work at a time.
// Synchronous active-low reset empties the table, max_retries = 2, delay = 100.
`default_nettype none

module request_retry_timeout_table import rrtt_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [DEST_W-1:0]   in_dest_eid,
  input  wire logic [INST_W-1:0]   in_instance_id,
  input  wire logic [HANDLE_W-1:0] in_request_handle,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_event_kind,
  output logic [DEST_W-1:0]        out_dest_eid,
  output logic [HANDLE_W-1:0]      out_handle,
  output logic [INST_W-1:0]        out_instance,
  output logic                     out_last,
  input  wire logic                cfg_we,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_wdata
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH_MUL,
    ST_PUSH_WR,
    ST_SINGLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t              state_r, state_nxt;
  op_t                 op_r, op_nxt;
  logic [DEST_W-1:0]   dest_r, dest_nxt;
  logic [INST_W-1:0]   inst_r, inst_nxt;
  logic [HANDLE_W-1:0] handle_r, handle_nxt;
  ev_kind_t            kind_r, kind_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    steps_r, steps_nxt;
  logic                hit_r, hit_nxt;
  logic                pend_vld_r, pend_vld_nxt;
  evt_t                pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  evt_t                out_ev_r, out_ev_nxt;
  logic                out_last_r, out_last_nxt;

  logic [RETRY_W-1:0]  max_retries_r;
  logic [DELAY_W-1:0]  retry_delay_r;
  logic [TIME_W-1:0]   prod_r;

  logic                slot_free;
  cell_ctl_t           ctl;
  entry_t              push_ent;
  entry_t              back_ent;
  logic                keep;
  logic                ev_vld;
  evt_t                ev;

  logic [TABLE_DEPTH-1:0] cell_vld;
  entry_t                 cell_ent [TABLE_DEPTH];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_retries_r <= RETRY_W'(2);
      retry_delay_r <= DELAY_W'(100);
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MAX_RETRIES: max_retries_r <= cfg_wdata[RETRY_W-1:0];
        CFG_RETRY_DELAY: retry_delay_r <= cfg_wdata[DELAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // retries * delay, registered; it settles in ST_PUSH_MUL before a push is written
  always_ff @(posedge clk) begin
    prod_r <= TIME_W'(max_retries_r) * TIME_W'(retry_delay_r);
  end

  assign push_ent.dest      = dest_r;
  assign push_ent.inst      = inst_r;
  assign push_ent.handle    = handle_r;
  assign push_ent.retries   = max_retries_r;
  assign push_ent.time_left = prod_r + TIME_W'(retry_delay_r);

  for (genvar gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
    logic   prev_v;
    logic   next_v;
    entry_t next_e;

    if (gi == 0) begin : g_first
      assign prev_v = 1'b1;
    end else begin : g_prev
      assign prev_v = cell_vld[gi-1];
    end

    if (gi == TABLE_DEPTH - 1) begin : g_last
      assign next_v = 1'b0;
      assign next_e = back_ent;
    end else begin : g_next
      assign next_v = cell_vld[gi+1];
      assign next_e = cell_ent[gi+1];
    end

    rrtt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_vld (prev_v),
      .next_vld (next_v),
      .next_ent (next_e),
      .push_ent (push_ent),
      .back_ent (back_ent),
      .vld      (cell_vld[gi]),
      .ent      (cell_ent[gi])
    );
  end

  rrtt_head u_head (
    .head_ent (cell_ent[0]),
    .op       (op_r),
    .inst     (inst_r),
    .hit      (hit_r),
    .delay    (retry_delay_r),
    .keep     (keep),
    .back_ent (back_ent),
    .ev_vld   (ev_vld),
    .ev       (ev)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dest_nxt      = dest_r;
    inst_nxt      = inst_r;
    handle_nxt    = handle_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    steps_nxt     = steps_r;
    hit_nxt       = hit_r;
    pend_vld_nxt  = pend_vld_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    ctl           = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt       = op_t'(in_opcode);
          dest_nxt     = in_dest_eid;
          inst_nxt     = in_instance_id;
          handle_nxt   = in_request_handle;
          hit_nxt      = 1'b0;
          pend_vld_nxt = 1'b0;
          steps_nxt    = cnt_r;
          case (op_t'(in_opcode))
            OP_PUSH: begin
              if (cnt_r == CNT_W'(TABLE_DEPTH)) begin
                kind_nxt  = EV_FULL;
                state_nxt = ST_SINGLE;
              end else begin
                state_nxt = ST_PUSH_MUL;
              end
            end
            OP_RESP: begin
              if (cnt_r == '0) begin
                kind_nxt   = EV_UNMATCHED;
                dest_nxt   = '0;
                handle_nxt = '0;
                state_nxt  = ST_SINGLE;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_TICK: begin
              if (cnt_r != '0) begin
                state_nxt = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PUSH_MUL: begin
        state_nxt = ST_PUSH_WR;
      end
      ST_PUSH_WR: begin
        ctl.load  = 1'b1;
        cnt_nxt   = cnt_r + CNT_W'(1);
        kind_nxt  = EV_TRANSMIT;
        state_nxt = ST_SINGLE;
      end
      ST_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          out_ev_nxt.kind   = kind_r;
          out_ev_nxt.dest   = dest_r;
          out_ev_nxt.handle = handle_r;
          out_ev_nxt.inst   = inst_r;
          out_last_nxt      = 1'b1;
          state_nxt         = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (slot_free) begin
          ctl.shift    = 1'b1;
          ctl.back_vld = keep;
          if (!keep) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          // hold one result back so the last one can be flagged
          if (ev_vld) begin
            if (pend_vld_r) begin
              out_valid_nxt = 1'b1;
              out_ev_nxt    = pend_r;
              out_last_nxt  = 1'b0;
            end
            pend_nxt     = ev;
            pend_vld_nxt = 1'b1;
            if (op_r == OP_RESP) begin
              hit_nxt = 1'b1;
            end
          end
          steps_nxt = steps_r - CNT_W'(1);
          if (steps_r == CNT_W'(1)) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (op_r == OP_RESP && !hit_r) begin
          kind_nxt   = EV_UNMATCHED;
          dest_nxt   = '0;
          handle_nxt = '0;
          state_nxt  = ST_SINGLE;
        end else if (!pend_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = pend_r;
          out_last_nxt  = 1'b1;
          pend_vld_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      hit_r       <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      hit_r       <= hit_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    dest_r     <= dest_nxt;
    inst_r     <= inst_nxt;
    handle_r   <= handle_nxt;
    kind_r     <= kind_nxt;
    steps_r    <= steps_nxt;
    pend_r     <= pend_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_ev_r.kind;
  assign out_dest_eid   = out_ev_r.dest;
  assign out_handle     = out_ev_r.handle;
  assign out_instance   = out_ev_r.inst;
  assign out_last       = out_last_r;

`include "request_retry_timeout_table_macros.svh"

  `RRTT_ASSERT_IMP(a_cnt_matches_cells, 1'b1, $countones(cell_vld) == int'(cnt_r), "count off")
  `RRTT_ASSERT_IMP(a_head_valid_in_scan, state_r == ST_SCAN, cell_vld[0], "empty head in scan")
  `RRTT_ASSERT_IMP(a_no_pending_idle, state_r == ST_IDLE, !pend_vld_r, "result left pending")
  `RRTT_ASSERT_NXT(a_push_grows, state_r == ST_PUSH_WR, cnt_r == $past(cnt_r) + CNT_W'(1),
                   "push lost")

endmodule

`default_nettype wire
